/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dbwc_pkg.sv */
package dbwc_pkg;

   // configuration port
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_RED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CROSS_RED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TGT_PCT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_TH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_TH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HIST_SHIFT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CROSS_MULT = 3'd7;

   // result action codes
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_SLOW   = 2'd1;
   localparam logic [1:0] ACT_ADD    = 2'd2;
   localparam logic [1:0] ACT_DEC    = 2'd3;

   // datapath step codes
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_PREP    = 4'd2;
   localparam logic [3:0] OP_TPEER   = 4'd3;
   localparam logic [3:0] OP_TECHO   = 4'd4;
   localparam logic [3:0] OP_MINMAX  = 4'd5;
   localparam logic [3:0] OP_SMOOTH  = 4'd6;
   localparam logic [3:0] OP_LIM     = 4'd7;
   localparam logic [3:0] OP_UPD     = 4'd8;
   localparam logic [3:0] OP_TGT     = 4'd9;
   localparam logic [3:0] OP_TGTDONE = 4'd10;
   localparam logic [3:0] OP_WIN     = 4'd11;
   localparam logic [3:0] OP_DEC     = 4'd12;
   localparam logic [3:0] OP_OUT     = 4'd13;

   // arithmetic constants
   localparam int          TREND_SHIFT      = 7;       // trend divisor 128
   localparam logic [31:0] MS_SCALE         = 32'd1000;
   localparam logic [13:0] PCT_SCALE        = 14'd100;
   localparam logic [31:0] WINDOW_FLOOR     = 32'd2;
   localparam logic [4:0]  SHIFT_MAX        = 5'd31;
   localparam int          SMOOTH_SHIFT     = 3;

   // reciprocal division: q = (x * RECIP) >> SHIFT, exact for any 32-bit x
   localparam logic [31:0] MS_RECIP         = 32'h1062_4DD3;  // 1000 ticks per second
   localparam int          MS_RECIP_SHIFT   = 38;
   localparam logic [31:0] PCT_RECIP        = 32'hD1B7_1759;  // percent times 100
   localparam int          PCT_RECIP_SHIFT  = 45;

   typedef struct packed {
      logic [3:0] op;
   } dbwc_ctrl_type;

   typedef struct packed {
      logic req_window;   // cmd bit of the offered item
      logic is_window;    // cmd bit of the item in work
      logic ss_done;      // slow start consumed every acked segment
      logic div_done;
      logic out_free;
   } dbwc_stat_type;

endpackage

/* rtl/core/dbwc_if.sv */
interface dbwc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] peer_stamp;
   logic [31:0] echo_stamp;
   logic [31:0] window_in;
   logic [31:0] slow_start_limit;
   logic [31:0] acked_count;

   modport source (output valid, cmd, peer_stamp, echo_stamp, window_in,
                   slow_start_limit, acked_count, input ready);
   modport sink   (input valid, cmd, peer_stamp, echo_stamp, window_in,
                   slow_start_limit, acked_count, output ready);
endinterface

interface dbwc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [31:0]        window_out;
   logic [31:0]        acked_left;
   logic [4:0]         shift_out;
   logic               cross_flag;
   logic [31:0]        delay_out;
   logic [31:0]        queue_delay;
   logic signed [31:0] target_delay;

   modport source (output valid, action, window_out, acked_left, shift_out, cross_flag,
                   delay_out, queue_delay, target_delay, input ready);
   modport sink   (input valid, action, window_out, acked_left, shift_out, cross_flag,
                   delay_out, queue_delay, target_delay, output ready);
endinterface

/* rtl/core/dbwc_div.sv */
// Divider by a fixed divisor (1000 or 10000) through reciprocal multiplication.
// Two steps: capture the dividend, then multiply; done pulses with the quotient.
module dbwc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic        use_pct,
   output logic [31:0] quotient,
   output logic        done
);

   logic [31:0] dvd_ff, dvd_in;
   logic        pct_ff, pct_in;
   logic        stage_ff, stage_in;
   logic [63:0] prod_ff, prod_in;
   logic        sel_ff, sel_in;
   logic        done_ff, done_in;
   logic [31:0] recip;
   logic [63:0] quo_wide;

   // capture the dividend
   always_comb begin
      dvd_in   = dvd_ff;
      pct_in   = pct_ff;
      stage_in = start;
      if (start) begin
         dvd_in = dividend;
         pct_in = use_pct;
      end
   end

   // multiply by the scaled reciprocal
   assign recip = pct_ff ? dbwc_pkg::PCT_RECIP : dbwc_pkg::MS_RECIP;

   always_comb begin
      prod_in = prod_ff;
      sel_in  = sel_ff;
      done_in = stage_ff;
      if (stage_ff) begin
         prod_in = {32'd0, dvd_ff} * {32'd0, recip};
         sel_in  = pct_ff;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      pct_ff  <= pct_in;
      prod_ff <= prod_in;
      sel_ff  <= sel_in;
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   assign quo_wide = sel_ff ? (prod_ff >> dbwc_pkg::PCT_RECIP_SHIFT) :
                              (prod_ff >> dbwc_pkg::MS_RECIP_SHIFT);
   assign quotient = quo_wide[31:0];
   assign done     = done_ff;

endmodule

/* rtl/core/dbwc_datapath.sv */
// State, configuration and arithmetic of the window controller
module dbwc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dbwc_pkg::dbwc_ctrl_type              ctrl,
   output dbwc_pkg::dbwc_stat_type              stat,
   input  logic                                 csr_we,
   input  logic [dbwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dbwc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   dbwc_req_if.sink                             req_bus,
   dbwc_rsp_if.source                           rsp_bus
);

   localparam int SMOOTH_SHIFT_C = dbwc_pkg::SMOOTH_SHIFT;

   // configuration
   logic [4:0]         min_red_ff, max_red_ff, cross_red_ff, hist_shift_ff;
   logic [6:0]         tgt_pct_ff;
   logic signed [10:0] rise_th_ff, fall_th_ff;
   logic [7:0]         cross_mult_ff;

   // item in work
   logic        cmd_ff, cmd_in;
   logic [31:0] peer_ff, peer_in, echo_ff, echo_in;
   logic [31:0] win_ff, win_in, ssl_ff, ssl_in, acked_ff, acked_in, left_ff, left_in;
   logic [1:0]  action_ff, action_in;
   logic        ss_done_ff, ss_done_in;
   logic [31:0] prod_echo_ff, prod_echo_in, tpeer_ff, tpeer_in;

   // controller state
   logic [31:0] delay_now_ff, delay_now_in, delay_low_ff, delay_low_in;
   logic [31:0] delay_high_ff, delay_high_in, smooth_low_ff, smooth_low_in;
   logic [31:0] smooth_high_ff, smooth_high_in, history_ff, history_in;
   logic [31:0] trend_avg_ff, trend_avg_in, echo_base_ff, echo_base_in;
   logic [31:0] peer_base_ff, peer_base_in, target_ff, target_in;
   logic [4:0]  shift_ff, shift_in;
   logic        cross_ff, cross_in;

   // intermediate terms
   logic signed [31:0] trend_ff, trend_in;
   logic signed [24:0] tdiv_ff, tdiv_in;
   logic signed [33:0] lim_ff, lim_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_action_ff, rsp_action_in;
   logic [31:0]        rsp_win_ff, rsp_win_in, rsp_left_ff, rsp_left_in;
   logic [4:0]         rsp_shift_ff, rsp_shift_in;
   logic               rsp_cross_ff, rsp_cross_in;
   logic [31:0]        rsp_delay_ff, rsp_delay_in, rsp_queue_ff, rsp_queue_in;
   logic [31:0]        rsp_target_ff, rsp_target_in;

   // divider hookup
   logic        div_start, div_use_pct, div_done;
   logic [31:0] div_dividend, div_q;

   // combinational helpers
   logic [31:0]        queue_now, pbase, ebase, low8, high8, span, win_red;
   logic [13:0]        pct_scaled;
   logic [45:0]        tgt_prod;
   logic [63:0]        peer_prod, echo_prod;
   logic signed [32:0] tsum;
   logic signed [32:0] tdiv_sh;
   logic signed [33:0] lim_c, trend_wide;
   logic               cross_nx;
   logic signed [6:0]  sh, lo;
   logic [32:0]        nw, cap;

   function automatic logic [31:0] ewma(input logic [31:0] smp, input logic [31:0] avg,
                                        input logic [4:0] s);
      logic [31:0] r;
      if (avg != 32'd0) r = avg + smp - (avg >> s);
      else              r = smp << s;
      return r;
   endfunction

   dbwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .use_pct  (div_use_pct),
      .quotient (div_q),
      .done     (div_done)
   );

   // shared terms
   assign queue_now  = (smooth_low_ff != 32'd0) ?
                       delay_now_ff - (smooth_low_ff >> SMOOTH_SHIFT_C) : 32'd0;
   assign pbase      = (peer_base_ff == 32'd0) ? peer_ff : peer_base_ff;
   assign ebase      = (echo_base_ff == 32'd0) ? echo_ff : echo_base_ff;
   assign peer_prod  = 64'(peer_ff - pbase) * 64'(dbwc_pkg::MS_SCALE);
   assign echo_prod  = 64'(echo_ff - ebase) * 64'(dbwc_pkg::MS_SCALE);
   assign low8       = delay_low_ff << SMOOTH_SHIFT_C;
   assign high8      = delay_high_ff << SMOOTH_SHIFT_C;
   assign span       = (smooth_high_ff - smooth_low_ff) >> SMOOTH_SHIFT_C;
   assign pct_scaled = 14'(14'(tgt_pct_ff) * dbwc_pkg::PCT_SCALE);
   assign tgt_prod   = 46'(pct_scaled) * 46'(span);
   // signed divide by 128, rounding toward zero
   assign tsum       = $signed({trend_avg_ff[31], trend_avg_ff}) +
                       (trend_avg_ff[31] ? 33'sd127 : 33'sd0);
   assign tdiv_sh    = tsum >>> dbwc_pkg::TREND_SHIFT;
   assign lim_c      = (lim_ff < 34'sd1) ? 34'sd1 : lim_ff;
   assign trend_wide = 34'(trend_ff);
   assign cross_nx   = cross_ff | ((history_ff != 32'd0) && (trend_avg_ff != 32'd0) &&
                                   (trend_wide > lim_c));
   assign win_red    = win_ff >> shift_ff;

   // shift update after a sample
   always_comb begin
      sh = $signed({2'b00, shift_ff});
      lo = cross_nx ? $signed({2'b00, cross_red_ff}) : $signed({2'b00, max_red_ff});
      if (trend_ff >= 32'(rise_th_ff)) begin
         sh = 7'(sh - 7'sd1);
         if (sh < lo) sh = lo;
      end else if (trend_ff <= 32'(fall_th_ff)) begin
         sh = 7'(sh + 7'sd1);
         if (sh > $signed({2'b00, min_red_ff})) sh = $signed({2'b00, min_red_ff});
      end
      if (sh < 7'sd0)  sh = 7'sd0;
      if (sh > 7'sd31) sh = 7'sd31;
   end

   // slow start terms
   always_comb begin
      nw  = {1'b0, win_ff} + {1'b0, acked_ff};
      cap = {1'b0, ssl_ff} + 33'd1;
      if (nw > cap) nw = cap;
   end

   // step logic
   always_comb begin
      cmd_in         = cmd_ff;
      peer_in        = peer_ff;
      echo_in        = echo_ff;
      win_in         = win_ff;
      ssl_in         = ssl_ff;
      acked_in       = acked_ff;
      left_in        = left_ff;
      action_in      = action_ff;
      ss_done_in     = ss_done_ff;
      prod_echo_in   = prod_echo_ff;
      tpeer_in       = tpeer_ff;
      delay_now_in   = delay_now_ff;
      delay_low_in   = delay_low_ff;
      delay_high_in  = delay_high_ff;
      smooth_low_in  = smooth_low_ff;
      smooth_high_in = smooth_high_ff;
      history_in     = history_ff;
      trend_avg_in   = trend_avg_ff;
      echo_base_in   = echo_base_ff;
      peer_base_in   = peer_base_ff;
      target_in      = target_ff;
      shift_in       = shift_ff;
      cross_in       = cross_ff;
      trend_in       = trend_ff;
      tdiv_in        = tdiv_ff;
      lim_in         = lim_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      rsp_action_in  = rsp_action_ff;
      rsp_win_in     = rsp_win_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_shift_in   = rsp_shift_ff;
      rsp_cross_in   = rsp_cross_ff;
      rsp_delay_in   = rsp_delay_ff;
      rsp_queue_in   = rsp_queue_ff;
      rsp_target_in  = rsp_target_ff;
      div_start      = 1'b0;
      div_use_pct    = 1'b0;
      div_dividend   = peer_prod[31:0];

      unique case (ctrl.op)
         dbwc_pkg::OP_LOAD: begin
            cmd_in     = req_bus.cmd;
            peer_in    = req_bus.peer_stamp;
            echo_in    = req_bus.echo_stamp;
            win_in     = req_bus.window_in;
            ssl_in     = req_bus.slow_start_limit;
            acked_in   = req_bus.acked_count;
            left_in    = '0;
            action_in  = dbwc_pkg::ACT_SAMPLE;
            ss_done_in = 1'b0;
         end
         dbwc_pkg::OP_PREP: begin
            peer_base_in = pbase;
            echo_base_in = ebase;
            prod_echo_in = echo_prod[31:0];
            div_start    = 1'b1;
         end
         dbwc_pkg::OP_TPEER: begin
            tpeer_in     = div_q;
            div_dividend = prod_echo_ff;
            div_start    = 1'b1;
         end
         dbwc_pkg::OP_TECHO: begin
            if (tpeer_ff > div_q) delay_now_in = tpeer_ff - div_q;
         end
         dbwc_pkg::OP_MINMAX: begin
            if (delay_now_ff < delay_low_ff)       delay_low_in  = delay_now_ff;
            else if (delay_now_ff > delay_high_ff) delay_high_in = delay_now_ff;
         end
         dbwc_pkg::OP_SMOOTH: begin
            if ((low8 < smooth_low_ff) || (smooth_low_ff == 32'd0))
               smooth_low_in = low8;
            else if (delay_low_ff > smooth_low_ff)
               smooth_low_in = ewma(delay_now_ff, smooth_low_ff, 5'(SMOOTH_SHIFT_C));
            if ((high8 > smooth_high_ff) || (smooth_high_ff == 32'd0))
               smooth_high_in = high8;
            else if (delay_high_ff > smooth_high_ff)
               smooth_high_in = ewma(delay_now_ff, smooth_high_ff, 5'(SMOOTH_SHIFT_C));
            trend_in = (history_ff != 32'd0) ?
                       $signed(delay_now_ff - (history_ff >> hist_shift_ff)) : 32'sd0;
            tdiv_in  = tdiv_sh[24:0];
         end
         dbwc_pkg::OP_LIM: begin
            lim_in = tdiv_ff * $signed({1'b0, cross_mult_ff});
         end
         dbwc_pkg::OP_UPD: begin
            cross_in   = cross_nx;
            shift_in   = sh[4:0];
            history_in = ewma(delay_now_ff, history_ff, hist_shift_ff);
            if (trend_avg_ff != 32'd0)
               trend_avg_in = trend_avg_ff - 32'(tdiv_ff) + trend_ff;
            else
               trend_avg_in = trend_ff <<< dbwc_pkg::TREND_SHIFT;
         end
         dbwc_pkg::OP_TGT: begin
            div_dividend = tgt_prod[31:0];
            div_use_pct  = 1'b1;
            div_start    = 1'b1;
         end
         dbwc_pkg::OP_TGTDONE: begin
            target_in = div_q;
         end
         dbwc_pkg::OP_WIN: begin
            if (win_ff <= ssl_ff) begin
               left_in    = acked_ff - 32'(nw - {1'b0, win_ff});
               win_in     = nw[32] ? '1 : nw[31:0];
               ss_done_in = (left_in == 32'd0);
            end else begin
               left_in = acked_ff;
            end
            action_in = dbwc_pkg::ACT_SLOW;
         end
         dbwc_pkg::OP_DEC: begin
            if (target_ff - queue_now >= 32'h8000_0000) begin
               win_in    = win_ff - win_red;
               if (shift_ff < dbwc_pkg::SHIFT_MAX) shift_in = 5'(shift_ff + 5'd1);
               action_in = dbwc_pkg::ACT_DEC;
               if (win_in < dbwc_pkg::WINDOW_FLOOR) win_in = dbwc_pkg::WINDOW_FLOOR;
            end else begin
               action_in = dbwc_pkg::ACT_ADD;
               if (win_ff < dbwc_pkg::WINDOW_FLOOR) win_in = dbwc_pkg::WINDOW_FLOOR;
            end
            delay_low_in  = '1;
            delay_high_in = '0;
            cross_in      = 1'b0;
         end
         dbwc_pkg::OP_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_action_in = action_ff;
            rsp_win_in    = win_ff;
            rsp_left_in   = left_ff;
            rsp_shift_in  = shift_ff;
            rsp_cross_in  = cross_ff;
            rsp_delay_in  = delay_now_ff;
            rsp_queue_in  = queue_now;
            rsp_target_in = target_ff;
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      peer_ff       <= peer_in;
      echo_ff       <= echo_in;
      win_ff        <= win_in;
      ssl_ff        <= ssl_in;
      acked_ff      <= acked_in;
      left_ff       <= left_in;
      action_ff     <= action_in;
      ss_done_ff    <= ss_done_in;
      prod_echo_ff  <= prod_echo_in;
      tpeer_ff      <= tpeer_in;
      target_ff     <= target_in;
      trend_ff      <= trend_in;
      tdiv_ff       <= tdiv_in;
      lim_ff        <= lim_in;
      rsp_action_ff <= rsp_action_in;
      rsp_win_ff    <= rsp_win_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_shift_ff  <= rsp_shift_in;
      rsp_cross_ff  <= rsp_cross_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_queue_ff  <= rsp_queue_in;
      rsp_target_ff <= rsp_target_in;
      if (reset) begin
         delay_now_ff   <= '0;
         delay_low_ff   <= '1;
         delay_high_ff  <= '0;
         smooth_low_ff  <= '0;
         smooth_high_ff <= '0;
         history_ff     <= '0;
         trend_avg_ff   <= '0;
         echo_base_ff   <= '0;
         peer_base_ff   <= '0;
         shift_ff       <= 5'd3;
         cross_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         delay_now_ff   <= delay_now_in;
         delay_low_ff   <= delay_low_in;
         delay_high_ff  <= delay_high_in;
         smooth_low_ff  <= smooth_low_in;
         smooth_high_ff <= smooth_high_in;
         history_ff     <= history_in;
         trend_avg_ff   <= trend_avg_in;
         echo_base_ff   <= echo_base_in;
         peer_base_ff   <= peer_base_in;
         shift_ff       <= shift_in;
         cross_ff       <= cross_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_red_ff    <= 5'd5;
         max_red_ff    <= 5'd3;
         cross_red_ff  <= 5'd0;
         tgt_pct_ff    <= 7'd15;
         rise_th_ff    <= 11'sd1;
         fall_th_ff    <= -11'sd1;
         hist_shift_ff <= 5'd2;
         cross_mult_ff <= 8'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            dbwc_pkg::REG_MIN_RED:    min_red_ff    <= csr_wdata[4:0];
            dbwc_pkg::REG_MAX_RED:    max_red_ff    <= csr_wdata[4:0];
            dbwc_pkg::REG_CROSS_RED:  cross_red_ff  <= csr_wdata[4:0];
            dbwc_pkg::REG_TGT_PCT:    tgt_pct_ff    <= csr_wdata[6:0];
            dbwc_pkg::REG_RISE_TH:    rise_th_ff    <= $signed(csr_wdata);
            dbwc_pkg::REG_FALL_TH:    fall_th_ff    <= $signed(csr_wdata);
            dbwc_pkg::REG_HIST_SHIFT: hist_shift_ff <= csr_wdata[4:0];
            dbwc_pkg::REG_CROSS_MULT: cross_mult_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // status and result port
   assign stat.req_window = req_bus.cmd;
   assign stat.is_window  = cmd_ff;
   assign stat.ss_done    = ss_done_ff;
   assign stat.div_done   = div_done;
   assign stat.out_free   = ~rsp_valid_ff | rsp_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.action       = rsp_action_ff;
   assign rsp_bus.window_out   = rsp_win_ff;
   assign rsp_bus.acked_left   = rsp_left_ff;
   assign rsp_bus.shift_out    = rsp_shift_ff;
   assign rsp_bus.cross_flag   = rsp_cross_ff;
   assign rsp_bus.delay_out    = rsp_delay_ff;
   assign rsp_bus.queue_delay  = rsp_queue_ff;
   assign rsp_bus.target_delay = $signed(rsp_target_ff);

endmodule

/* rtl/core/dbwc_ctrl.sv */
`include "assert_macros.svh"

// Sequencer that steps the datapath through one item
module dbwc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dbwc_pkg::dbwc_stat_type stat,
   output dbwc_pkg::dbwc_ctrl_type ctrl
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_DIV_P  = 4'd2;
   localparam logic [3:0] ST_DIV_E  = 4'd3;
   localparam logic [3:0] ST_MINMAX = 4'd4;
   localparam logic [3:0] ST_SMOOTH = 4'd5;
   localparam logic [3:0] ST_LIM    = 4'd6;
   localparam logic [3:0] ST_UPD    = 4'd7;
   localparam logic [3:0] ST_WIN    = 4'd8;
   localparam logic [3:0] ST_TGT    = 4'd9;
   localparam logic [3:0] ST_DIV_T  = 4'd10;
   localparam logic [3:0] ST_DEC    = 4'd11;
   localparam logic [3:0] ST_OUT    = 4'd12;

   logic [3:0] state_ff, state_in;

   // next state and step command
   always_comb begin
      state_in = state_ff;
      ctrl.op  = dbwc_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.op  = dbwc_pkg::OP_LOAD;
               state_in = stat.req_window ? ST_WIN : ST_PREP;
            end
         end
         ST_PREP: begin
            ctrl.op  = dbwc_pkg::OP_PREP;
            state_in = ST_DIV_P;
         end
         ST_DIV_P: begin
            if (stat.div_done) begin
               ctrl.op  = dbwc_pkg::OP_TPEER;
               state_in = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            if (stat.div_done) begin
               ctrl.op  = dbwc_pkg::OP_TECHO;
               state_in = ST_MINMAX;
            end
         end
         ST_MINMAX: begin
            ctrl.op  = dbwc_pkg::OP_MINMAX;
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            ctrl.op  = dbwc_pkg::OP_SMOOTH;
            state_in = ST_LIM;
         end
         ST_LIM: begin
            ctrl.op  = dbwc_pkg::OP_LIM;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            ctrl.op  = dbwc_pkg::OP_UPD;
            state_in = ST_TGT;
         end
         ST_WIN: begin
            ctrl.op  = dbwc_pkg::OP_WIN;
            state_in = ST_TGT;
         end
         ST_TGT: begin
            ctrl.op  = dbwc_pkg::OP_TGT;
            state_in = ST_DIV_T;
         end
         ST_DIV_T: begin
            if (stat.div_done) begin
               ctrl.op  = dbwc_pkg::OP_TGTDONE;
               state_in = (stat.is_window && !stat.ss_done) ? ST_DEC : ST_OUT;
            end
         end
         ST_DEC: begin
            ctrl.op  = dbwc_pkg::OP_DEC;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               ctrl.op  = dbwc_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

   // checks
   `ASSERT_IMPLIES(a_div_wait, clock, reset, stat.div_done,
      (state_ff == ST_DIV_P) || (state_ff == ST_DIV_E) || (state_ff == ST_DIV_T),
      "divider finished outside a wait state")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready,
      state_ff != ST_IDLE, "accepted item did not start work")
   `ASSERT_NEXT(a_out_done, clock, reset, (state_ff == ST_OUT) && stat.out_free,
      state_ff == ST_IDLE, "result stage did not release")

endmodule

/* rtl/core/delay_based_window_controller.sv */
// Channel  | Ports     | Direction | Carries
// request  | req_bus.* | in        | cmd, stamps, window, limit, acked count
// result   | rsp_bus.* | out       | action, window, acked left, shift, cross, delays
// config   | csr_*     | in        | write enable, register index, write data
//
// A sample item runs the delay divisions and the trend update; a window event runs the
// slow start step and, unless slow start uses every acked segment, the decrease step.
// Divisions run in the reciprocal divider (two for a sample, one for the target on every
// item). One item is in work at a time; the next is taken once the result is in the
// output register. Reset is synchronous and active high; the result register holds while
// rsp_bus.ready is low, which stalls the sequencer in its last step.
module delay_based_window_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   dbwc_req_if.sink                             req_bus,
   dbwc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [dbwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dbwc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   dbwc_pkg::dbwc_ctrl_type ctrl;
   dbwc_pkg::dbwc_stat_type stat;
   logic                    req_ready;

   dbwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   dbwc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   assign req_bus.ready = req_ready;

endmodule
